@@ src/mse_pkg.sv @@
package mse_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMECODE_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_FRAME = 2'd2;

  localparam logic [18:0] SAMPLE_RATE_RST     = 19'd48000;
  localparam logic        TIMECODE_SELECT_RST = 1'b0;
  localparam logic [7:0]  TICKS_PER_FRAME_RST = 8'd120;

  localparam logic [4:0] FPS_30 = 5'd30;
  localparam logic [4:0] FPS_25 = 5'd25;

  // datapath widths
  localparam int unsigned FRAME_W = 33;                 // frame_time + event_offset
  localparam int unsigned KMUL_W  = 13;                 // fps * ticks_per_frame
  localparam int unsigned PROD_W  = FRAME_W + KMUL_W;   // numerator
  localparam int unsigned DIVD_W  = PROD_W + 1;         // 2 * num + sr
  localparam int unsigned DIVS_W  = 20;                 // 2 * sr
  localparam int unsigned TICK_W  = 48;
  localparam int unsigned DELTA_W = 28;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned MUL_STEPS = FRAME_W;
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned MAX_BYTES = 7;
  localparam int unsigned NBYTE_W   = 3;
  localparam logic [DELTA_W-1:0] DELTA_MAX = 28'hFFF_FFFF;

  // commands
  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // event kinds
  localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_CONTROL  = 3'd2;
  localparam logic [2:0] KIND_PITCH    = 3'd3;
  localparam logic [2:0] KIND_PROGRAM  = 3'd4;

  // status and meta bytes
  localparam logic [7:0] STS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STS_CONTROL  = 8'hB0;
  localparam logic [7:0] STS_PITCH    = 8'hE0;
  localparam logic [7:0] STS_PROGRAM  = 8'hC0;
  localparam logic [7:0] META_DELTA0  = 8'h00;
  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] META_CHAN_PFX = 8'h20;
  localparam logic [7:0] META_LEN_ONE = 8'h01;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_LEN_ZERO = 8'h00;
  localparam logic [7:0] VLQ_MORE     = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DELTA,
    ST_LOAD
  } st_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  event_kind;
    logic [4:0]  channel;
    logic [31:0] frame_time;
    logic [15:0] event_offset;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
  } evt_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } trk_item_t;

  function automatic logic [7:0] status_base(input logic [2:0] kind);
    logic [7:0] base;
    unique case (kind)
      KIND_NOTE_ON:  base = STS_NOTE_ON;
      KIND_NOTE_OFF: base = STS_NOTE_OFF;
      KIND_CONTROL:  base = STS_CONTROL;
      KIND_PITCH:    base = STS_PITCH;
      KIND_PROGRAM:  base = STS_PROGRAM;
      default:       base = 8'h00;
    endcase
    return base;
  endfunction

endpackage

@@ src/mse_intf.sv @@
interface mse_evt_if;
  import mse_pkg::*;
  logic      valid;
  logic      ready;
  evt_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
  modport monitor (input valid, input item, input ready);
endinterface

interface mse_trk_if;
  import mse_pkg::*;
  logic      valid;
  logic      ready;
  trk_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
  modport monitor (input valid, input item, input ready);
endinterface

@@ src/midi_event_to_smf_track_encoder.sv @@
// Event command: the item runs through a bit-serial multiply, a prep step, a
// restoring divide and a delta step, then is loaded once the output is empty.
// Begin/end commands go straight from the transfer to the load step.
// A new item is taken once the previous one has loaded the 7-byte output shift
// register; bytes leave at one per cycle unless stalled, as the next item runs.
// Reset (rst_ni low, async): idle, output empty, previous tick 0, config defaults.
module midi_event_to_smf_track_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mse_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mse_evt_if.sink                          evt_i,
  mse_trk_if.source                        trk_o
);
  import mse_pkg::*;

  st_e st_q, st_d;

  logic [18:0]         sr_q;
  logic                tc_q;
  logic [7:0]          tpf_q;
  logic [TICK_W-1:0]   prev_q, prev_d;
  logic [7:0]          obuf_q [MAX_BYTES];
  logic [7:0]          obuf_d [MAX_BYTES];
  logic [NBYTE_W-1:0]  ocnt_q, ocnt_d;

  logic [1:0]          cmd_q;
  logic [2:0]          kind_q;
  logic [3:0]          chan_q;
  logic [6:0]          d1_q, d2_q;
  logic [KMUL_W-1:0]   k_q;
  logic [PROD_W-1:0]   p_q;
  logic [DIVD_W-1:0]   nq_q;
  logic [DIVS_W-1:0]   r_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DELTA_W-1:0]  delta_q;

  logic                evt_xfer, trk_xfer;
  logic                ld_go;
  logic [18:0]         sr_eff;
  logic [DIVS_W-1:0]   dvs;
  logic [KMUL_W:0]     mul_sum;
  logic [DIVS_W:0]     rem_try;
  logic                q_bit;
  logic [TICK_W-1:0]   tick;
  logic [TICK_W-1:0]   tick_diff;
  logic [7:0]          ld_buf [MAX_BYTES];
  logic [NBYTE_W-1:0]  ld_n;
  logic [7:0]          full [MAX_BYTES];
  logic [1:0]          lead;
  logic [3:0]          sel;

  // handshake and control
  always_comb begin
    evt_i.ready = (st_q == ST_IDLE);
    evt_xfer    = evt_i.valid && evt_i.ready;
    trk_xfer    = trk_o.valid && trk_o.ready;
    ld_go       = (st_q == ST_LOAD) && ((ocnt_q == '0) || (ld_n == '0));
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (evt_xfer) begin
          st_d = (evt_i.item.command == CMD_EVENT) ? ST_MUL : ST_LOAD;
        end
      end
      ST_MUL:   if (cnt_q == CNT_W'(MUL_STEPS - 1)) st_d = ST_PREP;
      ST_PREP:  st_d = ST_DIV;
      ST_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) st_d = ST_DELTA;
      ST_DELTA: st_d = ST_LOAD;
      ST_LOAD:  if (ld_go) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // arithmetic steps
  always_comb begin
    sr_eff    = (sr_q == '0) ? 19'd1 : sr_q;
    dvs       = {sr_eff, 1'b0};
    mul_sum   = {1'b0, p_q[PROD_W-1:FRAME_W]} + (p_q[0] ? {1'b0, k_q} : '0);
    rem_try   = {r_q, nq_q[DIVD_W-1]};
    q_bit     = (rem_try >= {1'b0, dvs});
    tick      = TICK_W'(nq_q);
    tick_diff = tick - prev_q;
  end

  // byte list for the output shift register
  always_comb begin
    lead = 2'd0;
    if (delta_q[27:21] != '0)      lead = 2'd3;
    else if (delta_q[20:14] != '0) lead = 2'd2;
    else if (delta_q[13:7] != '0)  lead = 2'd1;
    full[0] = VLQ_MORE | {1'b0, delta_q[27:21]};
    full[1] = VLQ_MORE | {1'b0, delta_q[20:14]};
    full[2] = VLQ_MORE | {1'b0, delta_q[13:7]};
    full[3] = {1'b0, delta_q[6:0]};
    full[4] = status_base(kind_q) + {4'h0, chan_q};
    full[5] = {1'b0, d1_q};
    full[6] = {1'b0, d2_q};
    sel = '0;
    for (int j = 0; j < MAX_BYTES; j++) begin
      ld_buf[j] = '0;
    end
    ld_n = '0;
    case (cmd_q)
      CMD_BEGIN: begin
        ld_buf[0] = META_DELTA0;
        ld_buf[1] = META_STATUS;
        ld_buf[2] = META_CHAN_PFX;
        ld_buf[3] = META_LEN_ONE;
        ld_buf[4] = {4'h0, chan_q};
        ld_n      = NBYTE_W'(5);
      end
      CMD_END: begin
        ld_buf[0] = META_DELTA0;
        ld_buf[1] = META_STATUS;
        ld_buf[2] = META_EOT;
        ld_buf[3] = META_LEN_ZERO;
        ld_n      = NBYTE_W'(4);
      end
      CMD_EVENT: begin
        if (kind_q <= KIND_PROGRAM) begin
          for (int j = 0; j < MAX_BYTES; j++) begin
            sel = 4'(j) + 4'(2'd3 - lead);
            ld_buf[j] = (sel < 4'(MAX_BYTES)) ? full[sel[2:0]] : '0;
          end
          ld_n = NBYTE_W'(lead) + NBYTE_W'(3) + ((kind_q == KIND_PROGRAM) ? '0 : NBYTE_W'(1));
        end
      end
      default: ld_n = '0;
    endcase
  end

  // output shift register and previous tick
  always_comb begin
    obuf_d = obuf_q;
    ocnt_d = ocnt_q;
    prev_d = prev_q;
    if (ld_go && (ld_n != '0)) begin
      obuf_d = ld_buf;
      ocnt_d = ld_n;
    end else if (trk_xfer) begin
      for (int j = 0; j < MAX_BYTES - 1; j++) begin
        obuf_d[j] = obuf_q[j+1];
      end
      obuf_d[MAX_BYTES-1] = '0;
      ocnt_d = ocnt_q - NBYTE_W'(1);
    end
    if (evt_xfer && (evt_i.item.command == CMD_BEGIN)) begin
      prev_d = '0;
    end else if (st_q == ST_DELTA) begin
      prev_d = tick;
    end
  end

  assign trk_o.valid          = (ocnt_q != '0);
  assign trk_o.item.out_byte  = obuf_q[0];
  assign trk_o.item.last_byte = (ocnt_q == NBYTE_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      sr_q   <= SAMPLE_RATE_RST;
      tc_q   <= TIMECODE_SELECT_RST;
      tpf_q  <= TICKS_PER_FRAME_RST;
      prev_q <= '0;
      ocnt_q <= '0;
    end else begin
      st_q   <= st_d;
      prev_q <= prev_d;
      ocnt_q <= ocnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_RATE:     sr_q  <= cfg_data_i[18:0];
          CFG_TIMECODE_SELECT: tc_q  <= cfg_data_i[0];
          CFG_TICKS_PER_FRAME: tpf_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
    unique case (st_q)
      ST_IDLE: begin
        if (evt_xfer) begin
          cmd_q  <= evt_i.item.command;
          kind_q <= evt_i.item.event_kind;
          chan_q <= 4'(evt_i.item.channel[3:0] + 4'hF);
          d1_q   <= evt_i.item.data_one;
          d2_q   <= evt_i.item.data_two;
          k_q    <= KMUL_W'(tc_q ? FPS_25 : FPS_30) * KMUL_W'(tpf_q);
          p_q    <= {{KMUL_W{1'b0}},
                     FRAME_W'(evt_i.item.frame_time) + FRAME_W'(evt_i.item.event_offset)};
          cnt_q  <= '0;
        end
      end
      ST_MUL: begin
        p_q   <= {mul_sum, p_q[FRAME_W-1:1]};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_PREP: begin
        nq_q  <= {p_q, 1'b0} + DIVD_W'(sr_eff);
        r_q   <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        r_q   <= q_bit ? DIVS_W'(rem_try - {1'b0, dvs}) : DIVS_W'(rem_try);
        nq_q  <= {nq_q[DIVD_W-2:0], q_bit};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_DELTA: begin
        if (tick <= prev_q) begin
          delta_q <= '0;
        end else if (tick_diff > TICK_W'(DELTA_MAX)) begin
          delta_q <= DELTA_MAX;
        end else begin
          delta_q <= tick_diff[DELTA_W-1:0];
        end
      end
      ST_LOAD: ;
      default: ;
    endcase
  end

endmodule

@@ src/mse_chk.sv @@
module mse_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               evt_valid_i,
  input logic               evt_ready_i,
  input logic               trk_valid_i,
  input logic               trk_ready_i,
  input mse_pkg::trk_item_t trk_item_i
);

  // stalled output byte holds
  a_trk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_valid_i && !trk_ready_i |=> trk_valid_i && $stable(trk_item_i))
    else $error("output byte dropped or changed under stall");

  // one item in flight at a time
  a_evt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("input taken while busy");

  // bytes of one item leave without a gap
  a_trk_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_valid_i && trk_ready_i && !trk_item_i.last_byte |=> trk_valid_i)
    else $error("gap inside a byte burst");

endmodule

bind midi_event_to_smf_track_encoder mse_chk u_mse_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .evt_valid_i (evt_i.valid),
  .evt_ready_i (evt_i.ready),
  .trk_valid_i (trk_o.valid),
  .trk_ready_i (trk_o.ready),
  .trk_item_i  (trk_o.item)
);
